// ===== src/ilcm_pkg.sv =====
package ilcm_pkg;

  localparam int IN_W       = 144;
  localparam int OUT_W      = 112;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int PIX_W      = 12;
  localparam int EN_W       = 20;
  localparam int REL_W      = 49;
  localparam int CNT_W      = 5;

  localparam logic [4:0] MAX_MATCH = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_SLOT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_CHANNEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIQUID_SLOT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIQUID_COUNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXELS_PER_ROW  = 3'd5;

  localparam logic [4:0]  RST_TRIGGER_SLOT    = 5'd31;
  localparam logic [4:0]  RST_TRIGGER_CHANNEL = 5'd31;
  localparam logic [4:0]  RST_LIQUID_SLOT     = 5'd30;
  localparam logic [5:0]  RST_LIQUID_COUNT    = 6'd16;
  localparam logic [19:0] RST_HALF_WINDOW     = 20'd100;
  localparam logic [11:0] RST_PIXELS_PER_ROW  = 12'd12;

  localparam logic [1:0] PT_NEUTRON = 2'd0;
  localparam logic [1:0] PT_THERMAL = 2'd1;
  localparam logic [1:0] PT_GAMMA   = 2'd2;
  localparam logic [1:0] PT_UNKNOWN = 2'd3;

  localparam logic [1:0] KIND_MATCH   = 1'b0;
  localparam logic [1:0] KIND_SUMMARY = 1'b1;

  localparam logic [19:0] E_MIN  = 20'd1600;
  localparam logic [15:0] PSD_LO = 16'd6554;
  localparam logic [15:0] PSD_HI = 16'd36044;
  localparam logic signed [15:0] ID_TWO      = 16'sd512;
  localparam logic signed [15:0] ID_NEG_TWO  = -16'sd512;
  localparam logic signed [15:0] ID_NEG_FIVE = -16'sd1280;

  typedef enum logic [1:0] {
    LQ_HEAD    = 2'd0,
    LQ_NEWEST  = 2'd1,
    LQ_POPNEXT = 2'd2,
    LQ_SCAN    = 2'd3
  } lq_sel_e;

  typedef struct packed {
    logic    accept;
    lq_sel_e lq_sel;
    logic    newest_ld;
    logic    lq_pop;
    logic    im_ld;
    logic    im_pop;
    logic    trig_init;
    logic    trig_step;
    logic    scan_init;
    logic    scan_step;
    logic    scan_done;
    logic    div_start;
    logic    emit_match;
    logic    emit_sum;
  } cmd_t;

  typedef struct packed {
    logic im_fill_nz;
    logic lq_fill_nz;
    logic lq_head_late;
    logic prune_go;
    logic im_late;
    logic im_known;
    logic trig_hit;
    logic trig_last;
    logic scan_more;
    logic scan_match;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic logic [1:0] classify(input logic [19:0] energy,
                                          input logic [15:0] psd,
                                          input logic signed [15:0] nid,
                                          input logic signed [15:0] gid);
    logic [1:0] ty;
    ty = PT_UNKNOWN;
    if (energy > E_MIN) begin
      if (nid > ID_NEG_TWO && nid < ID_TWO && gid < ID_NEG_FIVE) begin
        ty = PT_NEUTRON;
      end else if (psd >= PSD_LO && psd <= PSD_HI) begin
        ty = PT_THERMAL;
      end else if (gid > ID_NEG_TWO && gid < ID_TWO) begin
        ty = PT_GAMMA;
      end
    end
    return ty;
  endfunction

endpackage

// ===== src/ilcm_ram.sv =====
module ilcm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== src/ilcm_ctrl.sv =====
module ilcm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  ilcm_pkg::sts_t sts_i,
  output ilcm_pkg::cmd_t cmd_o
);
  typedef enum logic [14:0] {
    S_IDLE      = 15'h0001,
    S_LRD_HEAD  = 15'h0002,
    S_LCHK_HEAD = 15'h0004,
    S_LNEWEST   = 15'h0008,
    S_PRUNE     = 15'h0010,
    S_IRD       = 15'h0020,
    S_ICHK      = 15'h0040,
    S_TRD       = 15'h0080,
    S_TCHK      = 15'h0100,
    S_SCAN_INIT = 15'h0200,
    S_LS_RD     = 15'h0400,
    S_LS_CHK    = 15'h0800,
    S_EMIT_M    = 15'h1000,
    S_DIV       = 15'h2000,
    S_EMIT_S    = 15'h4000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.lq_sel = ilcm_pkg::LQ_HEAD;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_LRD_HEAD;
        end
      end
      S_LRD_HEAD: begin
        if (!sts_i.im_fill_nz && sts_i.lq_fill_nz) begin
          state_d = S_LCHK_HEAD;
        end else begin
          state_d = S_IRD;
        end
      end
      S_LCHK_HEAD: begin
        if (sts_i.lq_head_late) begin
          cmd_o.lq_sel = ilcm_pkg::LQ_NEWEST;
          state_d = S_LNEWEST;
        end else begin
          state_d = S_IRD;
        end
      end
      S_LNEWEST: begin
        cmd_o.newest_ld = 1'b1;
        state_d = S_PRUNE;
      end
      S_PRUNE: begin
        if (sts_i.prune_go) begin
          cmd_o.lq_pop = 1'b1;
          cmd_o.lq_sel = ilcm_pkg::LQ_POPNEXT;
        end else begin
          state_d = S_IRD;
        end
      end
      S_IRD: begin
        state_d = sts_i.im_fill_nz ? S_ICHK : S_IDLE;
      end
      S_ICHK: begin
        cmd_o.im_ld = 1'b1;
        if (sts_i.im_late) begin
          cmd_o.im_pop = 1'b1;
          if (sts_i.im_known) begin
            cmd_o.trig_init = 1'b1;
            state_d = S_TRD;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_TRD: begin
        state_d = S_TCHK;
      end
      S_TCHK: begin
        cmd_o.trig_step = 1'b1;
        state_d = (sts_i.trig_hit || sts_i.trig_last) ? S_SCAN_INIT : S_TRD;
      end
      S_SCAN_INIT: begin
        cmd_o.scan_init = 1'b1;
        state_d = S_LS_RD;
      end
      S_LS_RD: begin
        cmd_o.lq_sel = ilcm_pkg::LQ_SCAN;
        if (sts_i.scan_more) begin
          state_d = S_LS_CHK;
        end else begin
          cmd_o.scan_done = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_LS_CHK: begin
        cmd_o.scan_step = 1'b1;
        state_d = sts_i.scan_match ? S_EMIT_M : S_LS_RD;
      end
      S_EMIT_M: begin
        if (sts_i.out_free) begin
          cmd_o.emit_match = 1'b1;
          state_d = S_LS_RD;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_EMIT_S;
        end
      end
      S_EMIT_S: begin
        if (sts_i.out_free) begin
          cmd_o.emit_sum = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end
endmodule

// ===== src/ilcm_datapath.sv =====
module ilcm_datapath #(
  parameter int IMAGER_DEPTH  = 16,
  parameter int LIQUID_DEPTH  = 16,
  parameter int TRIGGER_DEPTH = 8,
  parameter int TIME_BITS     = 48
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ilcm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ilcm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [ilcm_pkg::IN_W-1:0]            s_tdata_i,
  input  ilcm_pkg::cmd_t                       cmd_i,
  output ilcm_pkg::sts_t                       sts_o,
  input  logic                                 m_tready_i,
  output logic                                 m_tvalid_o,
  output logic [ilcm_pkg::OUT_W-1:0]           m_tdata_o,
  output logic                                 m_tuser_o,
  output logic                                 m_tlast_o
);
  localparam int TW  = TIME_BITS;
  localparam int IAW = $clog2(IMAGER_DEPTH);
  localparam int IFW = $clog2(IMAGER_DEPTH + 1);
  localparam int LAW = $clog2(LIQUID_DEPTH);
  localparam int LFW = $clog2(LIQUID_DEPTH + 1);
  localparam int TAW = (TRIGGER_DEPTH > 1) ? $clog2(TRIGGER_DEPTH) : 1;
  localparam int IW  = TW + 34;
  localparam int LW  = TW + 27;
  localparam int DCW = $clog2(ilcm_pkg::PIX_W + 1);

  function automatic logic later(input logic [TW-1:0] a, input logic [TW-1:0] b,
                                 input logic [19:0] w);
    return (a >= b) && ((a - b) > TW'(w));
  endfunction

  function automatic logic [ilcm_pkg::REL_W-1:0] diff(input logic [TW-1:0] a,
                                                      input logic [TW-1:0] b);
    logic [63:0] d;
    d = 64'(a) - 64'(b);
    return d[ilcm_pkg::REL_W-1:0];
  endfunction

  function automatic logic [IAW-1:0] imod(input logic [IAW-1:0] base,
                                          input logic [IFW-1:0] off);
    logic [IFW:0] s;
    s = (IFW + 1)'(base) + (IFW + 1)'(off);
    if (s >= (IFW + 1)'(IMAGER_DEPTH)) s = s - (IFW + 1)'(IMAGER_DEPTH);
    return IAW'(s);
  endfunction

  function automatic logic [LAW-1:0] lmod(input logic [LAW-1:0] base,
                                          input logic [LFW-1:0] off);
    logic [LFW:0] s;
    s = (LFW + 1)'(base) + (LFW + 1)'(off);
    if (s >= (LFW + 1)'(LIQUID_DEPTH)) s = s - (LFW + 1)'(LIQUID_DEPTH);
    return LAW'(s);
  endfunction

  function automatic logic [TAW-1:0] tdec(input logic [TAW-1:0] p);
    return (p == '0) ? TAW'(TRIGGER_DEPTH - 1) : p - 1'b1;
  endfunction

  // configuration
  logic [4:0]  ts_q, tc_q, ls_q;
  logic [5:0]  lc_q;
  logic [19:0] w_q;
  logic [11:0] ppr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q  <= ilcm_pkg::RST_TRIGGER_SLOT;
      tc_q  <= ilcm_pkg::RST_TRIGGER_CHANNEL;
      ls_q  <= ilcm_pkg::RST_LIQUID_SLOT;
      lc_q  <= ilcm_pkg::RST_LIQUID_COUNT;
      w_q   <= ilcm_pkg::RST_HALF_WINDOW;
      ppr_q <= ilcm_pkg::RST_PIXELS_PER_ROW;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ilcm_pkg::CFG_TRIGGER_SLOT:    ts_q  <= cfg_data_i[4:0];
        ilcm_pkg::CFG_TRIGGER_CHANNEL: tc_q  <= cfg_data_i[4:0];
        ilcm_pkg::CFG_LIQUID_SLOT:     ls_q  <= cfg_data_i[4:0];
        ilcm_pkg::CFG_LIQUID_COUNT:    lc_q  <= cfg_data_i[5:0];
        ilcm_pkg::CFG_HALF_WINDOW:     w_q   <= cfg_data_i;
        ilcm_pkg::CFG_PIXELS_PER_ROW:  ppr_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // input unpack
  logic [4:0]         in_slot, in_chan;
  logic [TW-1:0]      in_t;
  logic [11:0]        in_pixel;
  logic [19:0]        in_energy;
  logic [15:0]        in_psd;
  logic signed [15:0] in_nid, in_gid;
  logic [1:0]         in_type;
  logic               is_trig, is_liq, is_img;

  assign in_slot   = s_tdata_i[4:0];
  assign in_chan   = s_tdata_i[9:5];
  assign in_t      = TW'(s_tdata_i[57:10]);
  assign in_pixel  = s_tdata_i[69:58];
  assign in_energy = s_tdata_i[89:70];
  assign in_psd    = s_tdata_i[105:90];
  assign in_nid    = s_tdata_i[121:106];
  assign in_gid    = s_tdata_i[137:122];
  assign in_type   = ilcm_pkg::classify(in_energy, in_psd, in_nid, in_gid);
  assign is_trig   = (in_slot == ts_q) && (in_chan == tc_q);
  assign is_liq    = !is_trig && (in_slot == ls_q);
  assign is_img    = !is_trig && !is_liq;

  logic [TW-1:0] t_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) t_q <= in_t;
  end

  // retiring imager entry
  logic [TW-1:0]  im_t_q;
  logic [33:0]    im_info_q;

  // trigger ring
  logic [TAW-1:0]           twi_q, tptr_q;
  logic [TAW-1:0]           tcnt_q;
  logic [TRIGGER_DEPTH-1:0] tvalid_q;
  logic                     tvld_rd_q;
  logic [TW-1:0]            trd, tval;
  logic                     t_we;
  logic                     tfound_q;
  logic [ilcm_pkg::REL_W-1:0] trel_q;

  assign t_we = cmd_i.accept && is_trig;

  ilcm_ram #(.WIDTH(TW), .DEPTH(TRIGGER_DEPTH)) u_trig_ram (
    .clk_i  (clk_i),
    .we_i   (t_we),
    .waddr_i(twi_q),
    .wdata_i(in_t),
    .raddr_i(tptr_q),
    .rdata_o(trd)
  );

  assign tval = tvld_rd_q ? trd : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      twi_q    <= '0;
      tvalid_q <= '0;
    end else if (t_we) begin
      tvalid_q[twi_q] <= 1'b1;
      twi_q <= (twi_q == TAW'(TRIGGER_DEPTH - 1)) ? '0 : twi_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    tvld_rd_q <= tvalid_q[tptr_q];
    if (cmd_i.trig_init) begin
      tptr_q   <= tdec(twi_q);
      tcnt_q   <= '0;
      tfound_q <= 1'b0;
      trel_q   <= '0;
    end else if (cmd_i.trig_step) begin
      if (sts_o.trig_hit) begin
        tfound_q <= 1'b1;
        trel_q   <= diff(im_t_q, tval);
      end else begin
        tptr_q <= tdec(tptr_q);
        tcnt_q <= tcnt_q + 1'b1;
      end
    end
  end

  // imager queue
  logic [IAW-1:0] ihead_q;
  logic [IFW-1:0] ifill_q;
  logic [IW-1:0]  ird;
  logic [TW-1:0]  ird_t;
  logic [33:0]    ird_info;
  logic           i_we;

  assign i_we     = cmd_i.accept && is_img && (ifill_q < IFW'(IMAGER_DEPTH));
  assign ird_t    = ird[IW-1:34];
  assign ird_info = ird[33:0];

  ilcm_ram #(.WIDTH(IW), .DEPTH(IMAGER_DEPTH)) u_img_ram (
    .clk_i  (clk_i),
    .we_i   (i_we),
    .waddr_i(imod(ihead_q, ifill_q)),
    .wdata_i({in_t, in_energy, in_pixel, in_type}),
    .raddr_i(ihead_q),
    .rdata_o(ird)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ihead_q <= '0;
      ifill_q <= '0;
    end else if (i_we) begin
      ifill_q <= ifill_q + 1'b1;
    end else if (cmd_i.im_pop) begin
      ihead_q <= imod(ihead_q, IFW'(1));
      ifill_q <= ifill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.im_ld) begin
      im_t_q    <= ird_t;
      im_info_q <= ird_info;
    end
  end

  // liquid queue
  logic [LAW-1:0] lhead_q;
  logic [LFW-1:0] lfill_q;
  logic [LW-1:0]  lrd;
  logic [TW-1:0]  lrd_t;
  logic [1:0]     lrd_type;
  logic [4:0]     lrd_ch;
  logic [19:0]    lrd_en;
  logic           l_acc_we, l_we;
  logic [LAW-1:0] l_waddr, l_raddr;
  logic [LW-1:0]  l_wdata;
  logic [TW-1:0]  newest_q;

  logic [LFW-1:0] r_q, wr_q;
  logic           stop_q;
  logic [4:0]     mcnt_q;
  logic [ilcm_pkg::CNT_W-1:0] ncnt_q, gcnt_q;
  logic [1:0]     m_type_q;
  logic [ilcm_pkg::REL_W-1:0] m_rel_q;
  logic [19:0]    m_en_q;
  logic           s_drop, s_after, s_keep, s_match, s_wr;

  assign lrd_t    = lrd[LW-1:27];
  assign lrd_en   = lrd[26:7];
  assign lrd_ch   = lrd[6:2];
  assign lrd_type = lrd[1:0];

  assign l_acc_we = cmd_i.accept && is_liq && (lfill_q < LFW'(LIQUID_DEPTH));
  assign s_drop   = (lrd_type == ilcm_pkg::PT_UNKNOWN) || later(im_t_q, lrd_t, w_q);
  assign s_after  = later(lrd_t, im_t_q, w_q);
  assign s_keep   = !stop_q && !s_drop && !s_after;
  assign s_match  = s_keep && ({1'b0, lrd_ch} < lc_q) && (mcnt_q < ilcm_pkg::MAX_MATCH);
  assign s_wr     = cmd_i.scan_step && (stop_q || !s_drop);

  assign l_we    = l_acc_we || s_wr;
  assign l_waddr = l_acc_we ? lmod(lhead_q, lfill_q) : lmod(lhead_q, wr_q);
  assign l_wdata = l_acc_we ? {in_t, in_energy, in_chan, in_type} : lrd;

  always_comb begin
    case (cmd_i.lq_sel)
      ilcm_pkg::LQ_NEWEST:  l_raddr = lmod(lhead_q, lfill_q - 1'b1);
      ilcm_pkg::LQ_POPNEXT: l_raddr = lmod(lhead_q, LFW'(1));
      ilcm_pkg::LQ_SCAN:    l_raddr = lmod(lhead_q, r_q);
      default:              l_raddr = lhead_q;
    endcase
  end

  ilcm_ram #(.WIDTH(LW), .DEPTH(LIQUID_DEPTH)) u_liq_ram (
    .clk_i  (clk_i),
    .we_i   (l_we),
    .waddr_i(l_waddr),
    .wdata_i(l_wdata),
    .raddr_i(l_raddr),
    .rdata_o(lrd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lhead_q <= '0;
      lfill_q <= '0;
    end else if (l_acc_we) begin
      lfill_q <= lfill_q + 1'b1;
    end else if (cmd_i.lq_pop) begin
      lhead_q <= lmod(lhead_q, LFW'(1));
      lfill_q <= lfill_q - 1'b1;
    end else if (cmd_i.scan_done) begin
      lfill_q <= wr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.newest_ld) newest_q <= lrd_t;
    if (cmd_i.scan_init) begin
      r_q    <= '0;
      wr_q   <= '0;
      stop_q <= 1'b0;
      mcnt_q <= '0;
      ncnt_q <= '0;
      gcnt_q <= '0;
    end else if (cmd_i.scan_step) begin
      r_q <= r_q + 1'b1;
      if (s_wr) wr_q <= wr_q + 1'b1;
      if (!stop_q && !s_drop && s_after) stop_q <= 1'b1;
      if (s_match) begin
        m_type_q <= lrd_type;
        m_rel_q  <= diff(lrd_t, im_t_q);
        m_en_q   <= lrd_en;
        mcnt_q   <= mcnt_q + 1'b1;
        if (im_info_q[1:0] == ilcm_pkg::PT_NEUTRON) ncnt_q <= ncnt_q + 1'b1;
        if (im_info_q[1:0] == ilcm_pkg::PT_GAMMA)   gcnt_q <= gcnt_q + 1'b1;
      end
    end
  end

  // pixel split, one quotient bit per cycle
  logic             div_busy_q;
  logic [DCW-1:0]   dcnt_q;
  logic [11:0]      rem_q, quo_q;
  logic [12:0]      remw;
  logic             rge;

  assign remw = {rem_q, quo_q[11]};
  assign rge  = remw >= {1'b0, ppr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= (ppr_q != '0);
    end else if (div_busy_q && dcnt_q == DCW'(1)) begin
      div_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dcnt_q <= DCW'(ilcm_pkg::PIX_W);
      if (ppr_q == '0) begin
        rem_q <= im_info_q[13:2];
        quo_q <= '0;
      end else begin
        rem_q <= '0;
        quo_q <= im_info_q[13:2];
      end
    end else if (div_busy_q) begin
      dcnt_q <= dcnt_q - 1'b1;
      rem_q  <= rge ? 12'(remw - {1'b0, ppr_q}) : remw[11:0];
      quo_q  <= {quo_q[10:0], rge};
    end
  end

  // output register
  logic        ovalid_q;
  logic        okind_q, olast_q, ofound_q;
  logic [1:0]  otype_q;
  logic [11:0] ox_q, oy_q;
  logic [ilcm_pkg::REL_W-1:0] orel_q;
  logic [19:0] oen_q;
  logic [ilcm_pkg::CNT_W-1:0] on_q, og_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit_match || cmd_i.emit_sum) begin
      ovalid_q <= 1'b1;
    end else if (m_tready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_match) begin
      okind_q  <= ilcm_pkg::KIND_MATCH[0];
      otype_q  <= m_type_q;
      ox_q     <= '0;
      oy_q     <= '0;
      orel_q   <= m_rel_q;
      ofound_q <= 1'b0;
      oen_q    <= m_en_q;
      on_q     <= '0;
      og_q     <= '0;
      olast_q  <= 1'b0;
    end else if (cmd_i.emit_sum) begin
      okind_q  <= ilcm_pkg::KIND_SUMMARY[0];
      otype_q  <= im_info_q[1:0];
      ox_q     <= rem_q;
      oy_q     <= quo_q;
      orel_q   <= trel_q;
      ofound_q <= tfound_q;
      oen_q    <= im_info_q[33:14];
      on_q     <= ncnt_q;
      og_q     <= gcnt_q;
      olast_q  <= 1'b1;
    end
  end

  assign m_tvalid_o = ovalid_q;
  assign m_tuser_o  = okind_q;
  assign m_tlast_o  = olast_q;
  assign m_tdata_o  = {6'd0, og_q, on_q, oen_q, ofound_q, orel_q, oy_q, ox_q, otype_q};

  // status
  assign sts_o.im_fill_nz   = (ifill_q != '0);
  assign sts_o.lq_fill_nz   = (lfill_q != '0);
  assign sts_o.lq_head_late = later(t_q, lrd_t, w_q);
  assign sts_o.prune_go     = (lfill_q != '0) && later(newest_q, lrd_t, w_q);
  assign sts_o.im_late      = later(t_q, ird_t, w_q);
  assign sts_o.im_known     = (ird_info[1:0] != ilcm_pkg::PT_UNKNOWN);
  assign sts_o.trig_hit     = (im_t_q > tval);
  assign sts_o.trig_last    = (tcnt_q == TAW'(TRIGGER_DEPTH - 1));
  assign sts_o.scan_more    = (r_q < lfill_q);
  assign sts_o.scan_match   = s_match;
  assign sts_o.div_done     = !div_busy_q;
  assign sts_o.out_free     = !ovalid_q || m_tready_i;
endmodule

// ===== src/imager_liquid_coincidence_matcher.sv =====
// Imager / liquid coincidence matcher.
// s_axis carries detector hits in time order; tdata holds slot, channel,
// time_ns, pixel, energy, psd, neutron_id, gamma_id. Trigger hits fill a ring,
// liquid hits and imager hits are queued in RAM.
// m_axis carries records: tuser is record_kind (0 match, 1 summary), tlast
// marks the summary that closes each group of matches.
// cfg_we_i/cfg_idx_i/cfg_data_i write the six setup registers; write only idle.
// One hit is taken at a time. Retiring a known imager entry searches up to
// TRIGGER_DEPTH trigger entries, scans the liquid queue with one match record
// per match and then runs the bit-serial pixel divider (skipped when
// pixels_per_row is zero). The single liquid RAM port pair sets the scan pace.
// A record waits in the output register while the next hit is accepted; a
// further record stalls the matcher until m_axis_tready frees that register.
// Reset empties the queues, clears the trigger ring and loads the register
// defaults; no clearing pass is needed.
module imager_liquid_coincidence_matcher #(
  parameter int IMAGER_DEPTH  = 16,
  parameter int LIQUID_DEPTH  = 16,
  parameter int TRIGGER_DEPTH = 8,
  parameter int TIME_BITS     = 48
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ilcm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ilcm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // slot, channel, time_ns, pixel, energy, psd, neutron_id, gamma_id
  input  logic [ilcm_pkg::IN_W-1:0]        s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // particle_type, pixel_x, pixel_y, relative_time, trigger_found, energy_out,
  // liquid_neutron_count, liquid_gamma_count
  output logic [ilcm_pkg::OUT_W-1:0]       m_axis_tdata,
  // record_kind
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast
);
  ilcm_pkg::cmd_t cmd;
  ilcm_pkg::sts_t sts;

  ilcm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  ilcm_datapath #(
    .IMAGER_DEPTH (IMAGER_DEPTH),
    .LIQUID_DEPTH (LIQUID_DEPTH),
    .TRIGGER_DEPTH(TRIGGER_DEPTH),
    .TIME_BITS    (TIME_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .s_tdata_i (s_axis_tdata),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .m_tready_i(m_axis_tready),
    .m_tvalid_o(m_axis_tvalid),
    .m_tdata_o (m_axis_tdata),
    .m_tuser_o (m_axis_tuser),
    .m_tlast_o (m_axis_tlast)
  );
endmodule

// ===== src/ilcm_checker.sv =====
module ilcm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [ilcm_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                       m_axis_tuser,
  input logic                       m_axis_tlast
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  a_match_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> !m_axis_tlast)
    else $error("match beat carries tlast");

  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("summary beat without tlast");

  a_match_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[105:96] == '0 && !m_axis_tdata[75] && m_axis_tdata[25:2] == '0)
    else $error("match beat has summary fields set");

  a_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != ilcm_pkg::PT_UNKNOWN)
    else $error("unknown particle type on output");
endmodule

bind imager_liquid_coincidence_matcher ilcm_checker u_ilcm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    logic [4:0]         slot;
    logic [4:0]         chan;
    logic [47:0]        t;
    logic [11:0]        pix;
    logic [19:0]        en;
    logic [15:0]        psd;
    logic signed [15:0] nid;
    logic signed [15:0] gid;
  } hit_t;

  typedef struct {
    logic        kind;
    logic [1:0]  ptype;
    logic [11:0] px;
    logic [11:0] py;
    logic [48:0] rel;
    logic        found;
    logic [19:0] en;
    logic [4:0]  ncnt;
    logic [4:0]  gcnt;
    logic        last;
  } rec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ilcm_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [ilcm_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [ilcm_pkg::IN_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [ilcm_pkg::OUT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  imager_liquid_coincidence_matcher u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always #4 clk_i = ~clk_i;

  hit_t hits_to_send[$];
  rec_t expected_records[$];
  hit_t hit_on_bus;
  int errors = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  logic [47:0] now_t = '0;

  // register mirror
  logic [4:0]  r_tslot = ilcm_pkg::RST_TRIGGER_SLOT, r_tch = ilcm_pkg::RST_TRIGGER_CHANNEL;
  logic [4:0]  r_lslot = ilcm_pkg::RST_LIQUID_SLOT;
  logic [5:0]  r_lcount = ilcm_pkg::RST_LIQUID_COUNT;
  logic [19:0] r_hw = ilcm_pkg::RST_HALF_WINDOW;
  logic [11:0] r_ppr = ilcm_pkg::RST_PIXELS_PER_ROW;

  // matcher state
  logic [47:0] trig_t[8];
  int          trig_wi = 0;
  logic [47:0] im_t[16];
  logic [1:0]  im_ty[16];
  logic [11:0] im_pix[16];
  logic [19:0] im_en[16];
  int          im_head = 0, im_fill = 0;
  logic [47:0] lq_t[16];
  logic [1:0]  lq_ty[16];
  logic [4:0]  lq_ch[16];
  logic [19:0] lq_en[16];
  int          lq_head = 0, lq_fill = 0;

  initial foreach (trig_t[i]) trig_t[i] = '0;

  function automatic logic later_by(logic [47:0] a, logic [47:0] b, logic [19:0] w);
    return a >= b && (a - b) > {28'd0, w};
  endfunction

  function automatic logic [1:0] hit_class(hit_t h);
    if (h.en <= 20'd1600) return ilcm_pkg::PT_UNKNOWN;
    if (h.nid > -16'sd512 && h.nid < 16'sd512 && h.gid < -16'sd1280)
      return ilcm_pkg::PT_NEUTRON;
    if (h.psd >= 16'd6554 && h.psd <= 16'd36044) return ilcm_pkg::PT_THERMAL;
    if (h.gid > -16'sd512 && h.gid < 16'sd512) return ilcm_pkg::PT_GAMMA;
    return ilcm_pkg::PT_UNKNOWN;
  endfunction

  function automatic void absorb_hit(hit_t h);
    int p, ih, r, wr, fill, n_match, idx;
    logic [47:0] newest, imt;
    logic [1:0] ity;
    logic [4:0] nc, gc;
    rec_t rec, mrec;
    if (h.slot == r_tslot && h.chan == r_tch) begin
      trig_t[trig_wi] = h.t;
      trig_wi = (trig_wi + 1) % 8;
    end else if (h.slot == r_lslot) begin
      if (lq_fill < 16) begin
        p = (lq_head + lq_fill) % 16;
        lq_t[p] = h.t; lq_ty[p] = hit_class(h); lq_ch[p] = h.chan; lq_en[p] = h.en;
        lq_fill++;
      end
    end else if (im_fill < 16) begin
      p = (im_head + im_fill) % 16;
      im_t[p] = h.t; im_ty[p] = hit_class(h); im_pix[p] = h.pix; im_en[p] = h.en;
      im_fill++;
    end

    if (im_fill == 0 && lq_fill > 0 && later_by(h.t, lq_t[lq_head], r_hw)) begin
      newest = lq_t[(lq_head + lq_fill - 1) % 16];
      while (lq_fill > 0 && later_by(newest, lq_t[lq_head], r_hw)) begin
        lq_head = (lq_head + 1) % 16;
        lq_fill--;
      end
    end

    if (im_fill > 0 && later_by(h.t, im_t[im_head], r_hw)) begin
      ih = im_head;
      imt = im_t[ih];
      ity = im_ty[ih];
      im_head = (im_head + 1) % 16;
      im_fill--;
      if (ity != ilcm_pkg::PT_UNKNOWN) begin
        rec = '{default: '0};
        for (int i = 0; i < 8; i++) begin
          idx = (trig_wi + 7 - i) % 8;
          if (imt > trig_t[idx]) begin
            rec.rel = {1'b0, imt} - {1'b0, trig_t[idx]};
            rec.found = 1'b1;
            break;
          end
        end
        nc = '0; gc = '0; r = 0; wr = 0; fill = lq_fill; n_match = 0;
        while (r < fill) begin
          p = (lq_head + r) % 16;
          if (lq_ty[p] == ilcm_pkg::PT_UNKNOWN || later_by(imt, lq_t[p], r_hw)) begin
            r++;
            continue;
          end
          if (later_by(lq_t[p], imt, r_hw)) break;
          if ({1'b0, lq_ch[p]} < r_lcount && n_match < 16) begin
            mrec = '{default: '0};
            mrec.kind = ilcm_pkg::KIND_MATCH[0];
            mrec.ptype = lq_ty[p];
            mrec.rel = {1'b0, lq_t[p]} - {1'b0, imt};
            mrec.en = lq_en[p];
            expected_records.insert(expected_records.size(), mrec);
            n_match++;
            if (ity == ilcm_pkg::PT_NEUTRON) nc++;
            if (ity == ilcm_pkg::PT_GAMMA) gc++;
          end
          idx = (lq_head + wr) % 16;
          lq_t[idx] = lq_t[p]; lq_ty[idx] = lq_ty[p];
          lq_ch[idx] = lq_ch[p]; lq_en[idx] = lq_en[p];
          wr++; r++;
        end
        while (r < fill) begin
          p = (lq_head + r) % 16;
          idx = (lq_head + wr) % 16;
          lq_t[idx] = lq_t[p]; lq_ty[idx] = lq_ty[p];
          lq_ch[idx] = lq_ch[p]; lq_en[idx] = lq_en[p];
          wr++; r++;
        end
        lq_fill = wr;
        rec.kind = ilcm_pkg::KIND_SUMMARY[0];
        rec.ptype = ity;
        if (r_ppr == 0) begin
          rec.px = im_pix[ih]; rec.py = '0;
        end else begin
          rec.px = im_pix[ih] % r_ppr; rec.py = im_pix[ih] / r_ppr;
        end
        rec.en = im_en[ih];
        rec.ncnt = nc; rec.gcnt = gc; rec.last = 1'b1;
        expected_records.insert(expected_records.size(), rec);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hit_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) absorb_hit(hit_on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (hits_to_send.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = hits_to_send[0];
          hits_to_send.delete(0);
          hit_on_bus <= nxt;
          s_axis_tdata <= {6'd0, nxt.gid, nxt.nid, nxt.psd, nxt.en, nxt.pix, nxt.t,
                           nxt.chan, nxt.slot};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= $urandom_range(99) >= snk_stall_pct;
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  always @(posedge clk_i) begin
    rec_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_records.size() == 0) begin
        report("unexpected beat", m_axis_tdata[63:0], 64'd0);
      end else begin
        e = expected_records[0];
        expected_records.delete(0);
        if (m_axis_tuser !== e.kind) report("record_kind", m_axis_tuser, e.kind);
        if (m_axis_tdata[1:0] !== e.ptype) report("particle_type", m_axis_tdata[1:0], e.ptype);
        if (m_axis_tdata[13:2] !== e.px) report("pixel_x", m_axis_tdata[13:2], e.px);
        if (m_axis_tdata[25:14] !== e.py) report("pixel_y", m_axis_tdata[25:14], e.py);
        if (m_axis_tdata[74:26] !== e.rel) report("relative_time", m_axis_tdata[74:26], e.rel);
        if (m_axis_tdata[75] !== e.found) report("trigger_found", m_axis_tdata[75], e.found);
        if (m_axis_tdata[95:76] !== e.en) report("energy_out", m_axis_tdata[95:76], e.en);
        if (m_axis_tdata[100:96] !== e.ncnt)
          report("liquid_neutron_count", m_axis_tdata[100:96], e.ncnt);
        if (m_axis_tdata[105:101] !== e.gcnt)
          report("liquid_gamma_count", m_axis_tdata[105:101], e.gcnt);
        if (m_axis_tlast !== e.last) report("last", m_axis_tlast, e.last);
      end
    end
  end

  task automatic add_hit(int dt, logic [4:0] slot, logic [4:0] chan, logic [11:0] pix,
                         logic [19:0] en, logic [15:0] psd, int nid, int gid);
    hit_t h;
    now_t = now_t + 48'(dt);
    h = '{slot, chan, now_t, pix, en, psd, 16'(nid), 16'(gid)};
    hits_to_send.insert(hits_to_send.size(), h);
  endtask

  task automatic write_reg(logic [ilcm_pkg::CFG_IDX_W-1:0] idx, logic [19:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(logic [4:0] ts, logic [4:0] tc, logic [4:0] ls, logic [5:0] lc,
                          logic [19:0] hw, logic [11:0] ppr);
    write_reg(ilcm_pkg::CFG_TRIGGER_SLOT, 20'(ts));
    write_reg(ilcm_pkg::CFG_TRIGGER_CHANNEL, 20'(tc));
    write_reg(ilcm_pkg::CFG_LIQUID_SLOT, 20'(ls));
    write_reg(ilcm_pkg::CFG_LIQUID_COUNT, 20'(lc));
    write_reg(ilcm_pkg::CFG_HALF_WINDOW, hw);
    write_reg(ilcm_pkg::CFG_PIXELS_PER_ROW, 20'(ppr));
    r_tslot = ts; r_tch = tc; r_lslot = ls; r_lcount = lc; r_hw = hw; r_ppr = ppr;
  endtask

  task automatic drain();
    while (hits_to_send.size() > 0 || s_axis_tvalid || expected_records.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic random_hits(int n);
    int r, cls, dt, span, nid, gid;
    logic [4:0] slot, chan;
    logic [19:0] en;
    logic [15:0] psd;
    for (int k = 0; k < n; k++) begin
      span = int'(r_hw) + 1;
      r = $urandom_range(99);
      if (r < 65) dt = $urandom_range(0, span);
      else if (r < 88) dt = $urandom_range(0, span / 8);
      else dt = span + $urandom_range(0, 3 * span);
      chan = 5'($urandom_range(31));
      cls = $urandom_range(3);
      en = 20'($urandom_range(1601, 1048575));
      psd = 16'($urandom_range(0, 6553));
      nid = $urandom_range(512, 32767);
      gid = $urandom_range(512, 32767);
      if ($urandom_range(1)) nid = -nid;
      if ($urandom_range(1)) gid = -gid;
      case (cls)
        0: begin
          nid = $urandom_range(0, 1022) - 511;
          gid = -$urandom_range(1281, 32768);
        end
        1: psd = 16'($urandom_range(6554, 36044));
        2: begin
          if ($urandom_range(1)) psd = 16'($urandom_range(36045, 65535));
          gid = $urandom_range(0, 1022) - 511;
        end
        default: en = 20'($urandom_range(0, 1600));
      endcase
      r = $urandom_range(99);
      if (r < 30) begin
        slot = r_lslot;
      end else if (r < 40) begin
        slot = r_tslot; chan = r_tch;
      end else if (r < 85) begin
        do begin
          slot = 5'($urandom_range(31)); chan = 5'($urandom_range(31));
        end while (slot == r_lslot || (slot == r_tslot && chan == r_tch));
      end else begin
        slot = 5'($urandom_range(31));
        en = 20'($urandom); psd = 16'($urandom); nid = $urandom_range(0, 65535); gid = $urandom;
      end
      add_hit(dt, slot, chan, 12'($urandom), en, psd, nid, gid);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_hit(10, 31, 31, 0, 0, 0, 0, 0);
    add_hit(5, 30, 3, 0, 2000, 0, 0, -2000);
    add_hit(10, 3, 7, 4095, 1048575, 0, -511, -32768);
    add_hit(20, 30, 0, 0, 1601, 0, 32767, 511);
    add_hit(0, 30, 31, 0, 5000, 6554, -32768, 0);
    add_hit(0, 30, 1, 0, 1600, 20000, 0, -2000);
    add_hit(5, 0, 0, 0, 3000, 36044, 512, 0);
    add_hit(0, 31, 30, 13, 3000, 36045, -512, -511);
    add_hit(1, 12, 5, 77, 1601, 6553, 511, -1280);
    add_hit(150, 30, 2, 0, 4000, 65535, -32768, 32);
    add_hit(50, 1, 1, 100, 9000, 7000, 600, 32767);
    add_hit(0, 31, 31, 0, 0, 0, 0, 0);
    add_hit(300, 30, 4, 0, 2500, 0, 10, -1281);
    add_hit(0, 2, 9, 2048, 2500, 0, 0, 100);
    for (int i = 0; i < 5; i++) add_hit(400, 31, 31, 0, 0, 0, 0, 0);
    add_hit(0, 30, 6, 0, 7000, 0, 0, -5000);
    add_hit(60, 30, 8, 0, 7000, 0, 0, 0);
    add_hit(250, 31, 31, 0, 0, 0, 0, 0);
    add_hit(300, 31, 31, 0, 0, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin set_regs(0, 0, 1, 0, 20'd0, 12'd1); src_idle_pct = 73; snk_stall_pct = 0; end
        1: begin
          set_regs(31, 0, 31, 32, 20'd1048575, 12'd4095);
          src_idle_pct = 0; snk_stall_pct = 73;
        end
        2: begin set_regs(5, 31, 0, 8, 20'd500, 12'd0); src_idle_pct = 22; snk_stall_pct = 22; end
        3: begin set_regs(17, 9, 22, 20, 20'd2000, 12'd7); src_idle_pct = 0; snk_stall_pct = 0; end
        default: begin
          set_regs(31, 31, 30, 16, 20'd150, 12'd12);
          src_idle_pct = 73; snk_stall_pct = 73;
        end
      endcase
      if (ph == 4) now_t = 48'hFFFF_FFF0_0000;
      else now_t = (48'(ph + 1) << 44) | 48'($urandom_range(0, 1 << 30));
      random_hits(22);
      drain();
    end

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ilcm_pkg.sv
src/ilcm_ram.sv
src/ilcm_ctrl.sv
src/ilcm_datapath.sv
src/imager_liquid_coincidence_matcher.sv
src/ilcm_checker.sv
tb/testbench.sv
